@@ design/pava_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pava_pkg: shared types and constants
// Vertex and queue item types, register indexes, reset values and the
// vertices-per-primitive lookup for the primitive assembly block.
// ----------------------------------------------------------------------------
package pava_pkg;

    // vertex limit per primitive
    localparam int MAX_PRIMITIVE_VERTICES = 3;
    // depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_VP_X   = 3'd1;
    localparam logic [2:0] REG_VP_Y   = 3'd2;
    localparam logic [2:0] REG_VP_W   = 3'd3;
    localparam logic [2:0] REG_VP_H   = 3'd4;

    // primitive modes
    localparam logic [1:0] MODE_POINTS    = 2'd0;
    localparam logic [1:0] MODE_LINES     = 2'd1;
    localparam logic [1:0] MODE_TRIANGLES = 2'd2;

    // reset values
    localparam logic [1:0]  RST_MODE  = MODE_TRIANGLES;
    localparam logic [12:0] RST_VP_X  = 13'd0;
    localparam logic [12:0] RST_VP_Y  = 13'd0;
    localparam logic [13:0] RST_VP_W  = 14'd640;
    localparam logic [13:0] RST_VP_H  = 14'd480;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_vertex;

    typedef struct packed {
        t_vertex vtx;
        logic    last;
    } t_qitem;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [13:0] width;
        logic [13:0] height;
    } t_viewport;

    // vertices needed per primitive; unused code acts as triangles
    function automatic logic [1:0] need_of(input logic [1:0] mode);
        logic [1:0] n;
        case (mode)
            MODE_POINTS: n = 2'd1;
            MODE_LINES:  n = 2'd2;
            default:     n = 2'd3;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

@@ design/pava_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pava_front: vertex collection
// Stores incoming vertices until the primitive is complete, then pushes
// every stored vertex into the queue in arrival order, marking the last.
// ----------------------------------------------------------------------------
module pava_front #(
    parameter int MAX_VERTS = pava_pkg::MAX_PRIMITIVE_VERTICES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_mode,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire pava_pkg::t_vertex i_vtx,
    output logic                  o_q_valid,
    input  wire logic             i_q_ready,
    output pava_pkg::t_qitem      o_q_item
);
    import pava_pkg::*;

    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);

    t_vertex       r_store [MAX_VERTS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_total;
    logic [IW-1:0] r_idx;
    logic          r_push;

    logic [1:0]    w_need_raw;
    logic [1:0]    w_need;
    logic [IW-1:0] w_slot;
    logic [1:0]    w_newcnt;
    logic          w_accept;
    logic          w_last;

    // classify: slot, count and completion
    assign w_need_raw = need_of(i_mode);
    assign w_need     = (w_need_raw > 2'(MAX_VERTS)) ? 2'(MAX_VERTS) : w_need_raw;
    assign w_slot     = (r_count > CW'(MAX_VERTS - 1)) ? IW'(MAX_VERTS - 1)
                                                       : IW'(r_count);
    assign w_newcnt   = 2'(w_slot) + 2'd1;
    assign o_s_tready = !r_push;
    assign w_accept   = i_s_tvalid && !r_push;

    // drain side
    assign w_last        = (2'(r_idx) + 2'd1) == 2'(r_total);
    assign o_q_valid     = r_push;
    assign o_q_item.vtx  = r_store[r_idx];
    assign o_q_item.last = w_last;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[w_slot] <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_push  <= 1'b0;
        end else if (w_accept) begin
            if (w_newcnt >= w_need) begin
                r_count <= '0;
                r_total <= CW'(w_newcnt);
                r_idx   <= '0;
                r_push  <= 1'b1;
            end else begin
                r_count <= CW'(w_newcnt);
            end
        end else if (r_push && i_q_ready) begin
            if (w_last) begin
                r_push <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // stored count stays below the vertex limit between primitives
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CW'(MAX_VERTS))
        else $error("front vertex count out of range");

endmodule
`default_nettype wire

@@ design/pava_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pava_fifo: front-to-back queue
// Small register queue of vertex items that decouples collection from the
// per-vertex arithmetic.
// ----------------------------------------------------------------------------
module pava_fifo #(
    parameter int DEPTH = pava_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire pava_pkg::t_qitem i_push_item,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output pava_pkg::t_qitem      o_pop_item
);
    import pava_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_qitem      r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_fill;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = r_fill != (PW+1)'(DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_item   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (PW+1)'(DEPTH))
        else $error("queue fill above depth");

endmodule
`default_nettype wire

@@ design/pava_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pava_back: perspective divide and viewport transform
// Radix-2 reciprocal of w, three ndc products into one product register, two
// window products, then an output register toward the stream.
// ----------------------------------------------------------------------------
module pava_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pava_pkg::t_viewport i_vp,
    input  wire logic                i_q_valid,
    output logic                     o_q_ready,
    input  wire pava_pkg::t_qitem    i_q_item,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [127:0]             o_m_tdata,
    output logic                     o_m_tlast,
    output logic                     o_m_tuser
);
    import pava_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_SAT  = 4'd2;
    localparam logic [3:0] S_MX   = 4'd3;
    localparam logic [3:0] S_MY   = 4'd4;
    localparam logic [3:0] S_MZ   = 4'd5;
    localparam logic [3:0] S_NZ   = 4'd6;
    localparam logic [3:0] S_WY   = 4'd7;
    localparam logic [3:0] S_WYD  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [5:0] DIV_TOP = 6'd32;

    logic [3:0]         r_state;
    t_vertex            r_vtx;
    logic               r_last;
    logic               r_neg;
    logic               r_zero;
    logic [31:0]        r_m;
    logic [31:0]        r_rem;
    logic [32:0]        r_q;
    logic [5:0]         r_bit;
    logic signed [31:0] r_inv;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_nx;
    logic signed [31:0] r_ny;
    logic signed [31:0] r_nz;
    logic signed [47:0] r_wprod;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;

    logic               r_ov;
    logic [127:0]       r_odata;
    logic               r_olast;
    logic               r_ozero;

    logic [32:0]        w_shift;
    logic               w_ge;
    logic [32:0]        w_diff;
    logic signed [31:0] w_inv;
    logic signed [31:0] w_nsat;
    logic signed [31:0] w_wsat;
    logic [12:0]        w_org;
    logic               w_out_free;

    // floor shift by 16 and clamp to 32 bits
    function automatic logic signed [31:0] ndc_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        if (s > 64'(S32_MAX))      return S32_MAX;
        else if (s < 64'(S32_MIN)) return S32_MIN;
        else                       return s[31:0];
    endfunction

    // halve with floor, add origin in Q16.16, clamp
    function automatic logic signed [31:0] win_sat(input logic signed [47:0] p,
                                                   input logic [12:0] org);
        logic signed [48:0] t;
        t = 49'(p >>> 1) + $signed({20'b0, org, 16'b0});
        if (t > 49'(S32_MAX))      return S32_MAX;
        else if (t < 49'(S32_MIN)) return S32_MIN;
        else                       return t[31:0];
    endfunction

    // one restoring divide step; dividend is 2^32
    assign w_shift = {r_rem, r_bit == DIV_TOP};
    assign w_ge    = w_shift >= {1'b0, r_m};
    assign w_diff  = w_shift - {1'b0, r_m};

    // signed clamp of the quotient
    always_comb begin
        if (r_zero) begin
            w_inv = S32_MAX;
        end else if (r_neg) begin
            w_inv = (r_q > 33'h0_8000_0000) ? S32_MIN : -$signed(r_q[31:0]);
        end else begin
            w_inv = (r_q > 33'h0_7FFF_FFFF) ? S32_MAX : $signed(r_q[31:0]);
        end
    end

    assign w_nsat     = ndc_sat(r_prod);
    assign w_org      = (r_state == S_WYD) ? i_vp.y : i_vp.x;
    assign w_wsat     = win_sat(r_wprod, w_org);
    assign w_out_free = !r_ov || i_m_tready;
    assign o_q_ready  = r_state == S_IDLE;

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_vtx  <= i_q_item.vtx;
                r_last <= i_q_item.last;
                r_neg  <= i_q_item.vtx.w[31];
                r_zero <= i_q_item.vtx.w == '0;
                r_m    <= i_q_item.vtx.w[31] ? (~i_q_item.vtx.w + 32'd1)
                                             : i_q_item.vtx.w;
                r_rem  <= '0;
                r_q    <= '0;
                r_bit  <= DIV_TOP;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
                r_q   <= {r_q[31:0], w_ge};
                r_bit <= r_bit - 6'd1;
            end
            S_SAT: r_inv <= w_inv;
            S_MX:  r_prod <= r_vtx.x * r_inv;
            S_MY: begin
                r_nx   <= w_nsat;
                r_prod <= r_vtx.y * r_inv;
            end
            S_MZ: begin
                r_ny   <= w_nsat;
                r_prod <= r_vtx.z * r_inv;
            end
            S_NZ: begin
                r_nz    <= w_nsat;
                r_wprod <= (33'(r_nx) + 33'sd65536) * $signed({1'b0, i_vp.width});
            end
            S_WY: begin
                r_wx    <= w_wsat;
                r_wprod <= (33'(r_ny) + 33'sd65536) * $signed({1'b0, i_vp.height});
            end
            S_WYD: r_wy <= w_wsat;
            default: begin
            end
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_q_valid) r_state <= S_DIV;
                S_DIV:   if (r_bit == '0) r_state <= S_SAT;
                S_SAT:   r_state <= S_MX;
                S_MX:    r_state <= S_MY;
                S_MY:    r_state <= S_MZ;
                S_MZ:    r_state <= S_NZ;
                S_NZ:    r_state <= S_WY;
                S_WY:    r_state <= S_WYD;
                S_WYD:   r_state <= S_OUT;
                S_OUT:   if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register; the next vertex may start while this one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_odata[31:0]   <= r_wx;
            r_odata[63:32]  <= r_wy;
            r_odata[95:64]  <= r_nz;
            r_odata[127:96] <= r_inv;
            r_olast         <= r_last;
            r_ozero         <= r_zero;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ozero;

    // a zero w always leaves the saturated reciprocal
    a_zero_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ozero) |-> (r_odata[127:96] == S32_MAX))
        else $error("zero w without saturated reciprocal");

    // the divide runs exactly until its bit counter is spent
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == '0) |=> (r_state == S_SAT))
        else $error("divide did not finish on the last bit");

endmodule
`default_nettype wire

@@ design/primitive_assembly_viewport_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A primitive's vertices reach the output only after its last vertex is
// accepted. The single back-end sequencer takes one vertex at a time and
// accepts no new one until the 33-step radix-2 divide and the multiply and
// window steps are done and the result is handed to the output register.
// Reset (synchronous, active low) clears counts, queue and output valid and
// loads the register defaults: triangles, origin 0,0, viewport 640 by 480.
// ----------------------------------------------------------------------------
// primitive_assembly_viewport_transform: top level
// Configuration registers, vertex collection front, queue and the
// perspective divide / viewport back end.
// ----------------------------------------------------------------------------
module primitive_assembly_viewport_transform #(
    parameter int MAX_PRIMITIVE_VERTICES = pava_pkg::MAX_PRIMITIVE_VERTICES,
    parameter int QUEUE_DEPTH            = pava_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [13:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // clip_x [31:0], clip_y [63:32], clip_z [95:64], clip_w [127:96]
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // window_x [31:0], window_y [63:32], ndc_z [95:64], inv_w [127:96]
    output logic [127:0]      m_axis_tdata,
    // w_was_zero [0]
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    import pava_pkg::*;

    logic [1:0] r_mode;
    t_viewport  r_vp;
    t_vertex    w_vtx;
    logic       w_fq_valid;
    logic       w_fq_ready;
    t_qitem     w_fq_item;
    logic       w_qb_valid;
    logic       w_qb_ready;
    t_qitem     w_qb_item;

    assign o_cfg_ready = 1'b1;
    assign w_vtx       = s_axis_tdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_vp.x      <= RST_VP_X;
            r_vp.y      <= RST_VP_Y;
            r_vp.width  <= RST_VP_W;
            r_vp.height <= RST_VP_H;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE: r_mode      <= i_cfg_data[1:0];
                REG_VP_X: r_vp.x      <= i_cfg_data[12:0];
                REG_VP_Y: r_vp.y      <= i_cfg_data[12:0];
                REG_VP_W: r_vp.width  <= i_cfg_data;
                REG_VP_H: r_vp.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pava_front #(
        .MAX_VERTS (MAX_PRIMITIVE_VERTICES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_vtx      (w_vtx),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_item   (w_fq_item)
    );

    pava_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_item  (w_fq_item),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_item   (w_qb_item)
    );

    pava_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vp       (r_vp),
        .i_q_valid  (w_qb_valid),
        .o_q_ready  (w_qb_ready),
        .i_q_item   (w_qb_item),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
